### design/pn_pkg.sv
// Shared constants and stage payload types for the proportional navigation pipeline.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package pn_pkg;

    localparam int STATE_DIMS   = 3;
    localparam int CONTROL_DIMS = 3;

    // Quotient bits of the projection divide, of the speed ratio divide, root bits.
    localparam int T_STEPS    = 32;
    localparam int K_STEPS    = 128;
    localparam int SQRT_STEPS = 64;

    localparam int PADDR_W = 3;

    localparam logic [15:0] NAV_GAIN_RESET = 16'd768;
    localparam logic        REG_NAV_GAIN   = 1'b0;

    // Leaves the front end: components, dot products, projection numerators.
    typedef struct packed {
        logic [31:0]       tag;
        logic              rzero;
        logic [2:0]        tneg;
        logic [2:0][31:0]  vel;
        logic [2:0][95:0]  num;
        logic [63:0]       p;
        logic [63:0]       q;
    } front_t;

    // Leaves the divider: perpendicular velocity and speed ratio squared.
    typedef struct packed {
        logic [31:0]       tag;
        logic              rzero;
        logic [2:0]        wneg;
        logic [2:0][33:0]  wmag;
        logic [127:0]      ratio;
    } mid_t;

    // Leaves the square root: perpendicular velocity and |v|/|r| in Q.32.
    typedef struct packed {
        logic [31:0]       tag;
        logic              rzero;
        logic [2:0]        wneg;
        logic [2:0][33:0]  wmag;
        logic [63:0]       k;
    } root_t;

endpackage

`default_nettype wire

### design/pn_front.sv
// Front end: input capture, magnitudes, dot products and projection numerators.
// Uses pn_pkg for dimensions and the front_t payload; six register stages.
`default_nettype none

module pn_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_tag,
    input  logic signed [31:0]  in_pos_x,
    input  logic signed [31:0]  in_pos_y,
    input  logic signed [31:0]  in_pos_z,
    input  logic signed [31:0]  in_vel_x,
    input  logic signed [31:0]  in_vel_y,
    input  logic signed [31:0]  in_vel_z,
    output logic                out_valid,
    output pn_pkg::front_t      out_data
);

    logic [5:0] vld_reg;

    logic [31:0]      t0_reg;
    logic [2:0][31:0] pos0_reg, vel0_reg;

    logic [31:0]      t1_reg;
    logic [2:0]       rneg1_reg, xneg1_reg, rneg1_next, xneg1_next;
    logic [2:0][31:0] rmag1_reg, vel1_reg, rmag1_next, vmag1;
    logic [2:0][63:0] rr1_reg, vv1_reg, rv1_reg, rr1_next, vv1_next, rv1_next;

    logic [31:0]      t2_reg;
    logic [2:0]       rneg2_reg;
    logic [2:0][31:0] rmag2_reg, vel2_reg;
    logic [63:0]      p2_reg, q2_reg, dpos2_reg, dneg2_reg;
    logic [63:0]      p2_next, q2_next, dpos2_next, dneg2_next;

    logic [31:0]      t3_reg;
    logic [2:0][31:0] rmag3_reg, vel3_reg;
    logic [63:0]      p3_reg, q3_reg, dmag3_reg, dmag3_next;
    logic [2:0]       tneg3_reg, tneg3_next;
    logic             rzero3_reg, dsign3;

    logic [31:0]      t4_reg;
    logic [2:0][31:0] vel4_reg;
    logic [63:0]      p4_reg, q4_reg;
    logic [2:0]       tneg4_reg;
    logic             rzero4_reg;
    logic [2:0][63:0] pl4_reg, ph4_reg, pl4_next, ph4_next;

    pn_pkg::front_t   out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = out_reg;

    // Stage 1: magnitudes and the nine component products.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rneg1_next[i] = pos0_reg[i][31];
            xneg1_next[i] = pos0_reg[i][31] ^ vel0_reg[i][31];
            rmag1_next[i] = pos0_reg[i][31] ? (~pos0_reg[i] + 32'd1) : pos0_reg[i];
            vmag1[i]      = vel0_reg[i][31] ? (~vel0_reg[i] + 32'd1) : vel0_reg[i];
            rr1_next[i]   = 64'(rmag1_next[i]) * 64'(rmag1_next[i]);
            vv1_next[i]   = 64'(vmag1[i]) * 64'(vmag1[i]);
            rv1_next[i]   = 64'(rmag1_next[i]) * 64'(vmag1[i]);
        end
    end

    // Stage 2: range squared, speed squared, split dot product.
    always_comb begin
        p2_next    = rr1_reg[0] + rr1_reg[1] + rr1_reg[2];
        q2_next    = vv1_reg[0] + vv1_reg[1] + vv1_reg[2];
        dpos2_next = '0;
        dneg2_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (xneg1_reg[i]) begin
                dneg2_next = dneg2_next + rv1_reg[i];
            end else begin
                dpos2_next = dpos2_next + rv1_reg[i];
            end
        end
    end

    // Stage 3: signed dot product as magnitude and sign.
    always_comb begin
        dsign3     = dneg2_reg > dpos2_reg;
        dmag3_next = dsign3 ? (dneg2_reg - dpos2_reg) : (dpos2_reg - dneg2_reg);
        for (int i = 0; i < 3; i++) begin
            tneg3_next[i] = rneg2_reg[i] ^ dsign3;
        end
    end

    // Stage 4: |r_i| * |d| as two 32x32 partial products.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pl4_next[i] = 64'(rmag3_reg[i]) * 64'(dmag3_reg[31:0]);
            ph4_next[i] = 64'(rmag3_reg[i]) * 64'(dmag3_reg[63:32]);
        end
    end

    // Stage 5: combine and add half the divisor for round to nearest.
    always_comb begin
        out_next.tag   = t4_reg;
        out_next.rzero = rzero4_reg;
        out_next.tneg  = tneg4_reg;
        out_next.vel   = vel4_reg;
        out_next.p     = p4_reg;
        out_next.q     = q4_reg;
        for (int i = 0; i < 3; i++) begin
            out_next.num[i] = 96'(pl4_reg[i]) + {ph4_reg[i], 32'd0} + 96'(p4_reg[63:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg      <= in_tag;
            pos0_reg[0] <= in_pos_x;
            pos0_reg[1] <= in_pos_y;
            pos0_reg[2] <= (pn_pkg::STATE_DIMS == 2) ? 32'd0 : in_pos_z;
            vel0_reg[0] <= in_vel_x;
            vel0_reg[1] <= in_vel_y;
            vel0_reg[2] <= (pn_pkg::STATE_DIMS == 2) ? 32'd0 : in_vel_z;

            t1_reg      <= t0_reg;
            rneg1_reg   <= rneg1_next;
            xneg1_reg   <= xneg1_next;
            rmag1_reg   <= rmag1_next;
            vel1_reg    <= vel0_reg;
            rr1_reg     <= rr1_next;
            vv1_reg     <= vv1_next;
            rv1_reg     <= rv1_next;

            t2_reg      <= t1_reg;
            rneg2_reg   <= rneg1_reg;
            rmag2_reg   <= rmag1_reg;
            vel2_reg    <= vel1_reg;
            p2_reg      <= p2_next;
            q2_reg      <= q2_next;
            dpos2_reg   <= dpos2_next;
            dneg2_reg   <= dneg2_next;

            t3_reg      <= t2_reg;
            rmag3_reg   <= rmag2_reg;
            vel3_reg    <= vel2_reg;
            p3_reg      <= p2_reg;
            q3_reg      <= q2_reg;
            dmag3_reg   <= dmag3_next;
            tneg3_reg   <= tneg3_next;
            rzero3_reg  <= (p2_reg == 64'd0);

            t4_reg      <= t3_reg;
            vel4_reg    <= vel3_reg;
            p4_reg      <= p3_reg;
            q4_reg      <= q3_reg;
            tneg4_reg   <= tneg3_reg;
            rzero4_reg  <= rzero3_reg;
            pl4_reg     <= pl4_next;
            ph4_reg     <= ph4_next;

            out_reg     <= out_next;
        end
    end

endmodule

`default_nettype wire

### design/pn_div.sv
// Pipelined restoring dividers: projection t_i = num_i / P and the speed ratio Q*2^64 / P.
// Uses pn_pkg for step counts and the front_t / mid_t payloads; one quotient bit per stage.
`default_nettype none

module pn_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  pn_pkg::front_t  in_data,
    output logic            out_valid,
    output pn_pkg::mid_t    out_data
);

    typedef struct packed {
        logic [31:0]       tag;
        logic              rzero;
        logic [2:0]        tneg;
        logic [2:0][31:0]  vel;
        logic [63:0]       p;
        logic [63:0]       qsh;
        logic [63:0]       krem;
        logic [127:0]      kq;
        logic [2:0][63:0]  trem;
        logic [2:0][31:0]  tlo;
        logic [2:0][31:0]  tq;
    } kstage_t;

    kstage_t                     st_in;
    kstage_t                     st_reg [0:pn_pkg::K_STEPS-1];
    logic [pn_pkg::K_STEPS-1:0]  vld_reg;
    logic                        out_vld_reg;
    pn_pkg::mid_t                out_reg, out_next;

    always_comb begin
        st_in.tag   = in_data.tag;
        st_in.rzero = in_data.rzero;
        st_in.tneg  = in_data.tneg;
        st_in.vel   = in_data.vel;
        st_in.p     = in_data.p;
        st_in.qsh   = in_data.q;
        st_in.krem  = '0;
        st_in.kq    = '0;
        st_in.tq    = '0;
        // Projection quotient fits 32 bits, so the top of the numerator is already below P.
        for (int i = 0; i < 3; i++) begin
            st_in.trem[i] = in_data.num[i][95:32];
            st_in.tlo[i]  = in_data.num[i][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[pn_pkg::K_STEPS-2:0], in_valid};
            out_vld_reg <= vld_reg[pn_pkg::K_STEPS-1];
        end
    end

    for (genvar j = 0; j < pn_pkg::K_STEPS; j++) begin : g_step
        kstage_t st_cur, st_next;

        if (j == 0) begin : g_first
            assign st_cur = st_in;
        end else begin : g_rest
            assign st_cur = st_reg[j-1];
        end

        always_comb begin
            logic [64:0] kb, kd, tb, td;
            logic        kge, tge;
            st_next = st_cur;
            // Ratio divide: dividend bits come off the top of Q, zeros after.
            kb  = {st_cur.krem, st_cur.qsh[63]};
            kd  = kb - {1'b0, st_cur.p};
            kge = (kb >= {1'b0, st_cur.p});
            st_next.krem = kge ? kd[63:0] : kb[63:0];
            st_next.kq   = {st_cur.kq[126:0], kge};
            st_next.qsh  = {st_cur.qsh[62:0], 1'b0};
            if (j < pn_pkg::T_STEPS) begin
                for (int i = 0; i < 3; i++) begin
                    tb  = {st_cur.trem[i], st_cur.tlo[i][31]};
                    td  = tb - {1'b0, st_cur.p};
                    tge = (tb >= {1'b0, st_cur.p});
                    st_next.trem[i] = tge ? td[63:0] : tb[63:0];
                    st_next.tlo[i]  = {st_cur.tlo[i][30:0], 1'b0};
                    st_next.tq[i]   = {st_cur.tq[i][30:0], tge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    // Perpendicular velocity w = v -/+ t, as sign and magnitude.
    always_comb begin
        logic [33:0] vx, tx, w;
        out_next.tag   = st_reg[pn_pkg::K_STEPS-1].tag;
        out_next.rzero = st_reg[pn_pkg::K_STEPS-1].rzero;
        out_next.ratio = st_reg[pn_pkg::K_STEPS-1].kq;
        for (int i = 0; i < 3; i++) begin
            vx = {{2{st_reg[pn_pkg::K_STEPS-1].vel[i][31]}}, st_reg[pn_pkg::K_STEPS-1].vel[i]};
            tx = {2'b00, st_reg[pn_pkg::K_STEPS-1].tq[i]};
            w  = st_reg[pn_pkg::K_STEPS-1].tneg[i] ? (vx + tx) : (vx - tx);
            out_next.wneg[i] = w[33];
            out_next.wmag[i] = w[33] ? (~w + 34'd1) : w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### design/pn_sqrt.sv
// Pipelined digit-by-digit integer square root of the 128-bit speed ratio.
// Uses pn_pkg for the step count and the mid_t / root_t payloads; one root bit per stage.
`default_nettype none

module pn_sqrt (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  pn_pkg::mid_t    in_data,
    output logic            out_valid,
    output pn_pkg::root_t   out_data
);

    typedef struct packed {
        logic [31:0]       tag;
        logic              rzero;
        logic [2:0]        wneg;
        logic [2:0][33:0]  wmag;
        logic [127:0]      n;
        logic [65:0]       rem;
        logic [63:0]       root;
    } sstage_t;

    sstage_t                        st_in;
    sstage_t                        st_reg [0:pn_pkg::SQRT_STEPS-1];
    logic [pn_pkg::SQRT_STEPS-1:0]  vld_reg;

    always_comb begin
        st_in.tag   = in_data.tag;
        st_in.rzero = in_data.rzero;
        st_in.wneg  = in_data.wneg;
        st_in.wmag  = in_data.wmag;
        st_in.n     = in_data.ratio;
        st_in.rem   = '0;
        st_in.root  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[pn_pkg::SQRT_STEPS-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < pn_pkg::SQRT_STEPS; j++) begin : g_step
        sstage_t st_cur, st_next;

        if (j == 0) begin : g_first
            assign st_cur = st_in;
        end else begin : g_rest
            assign st_cur = st_reg[j-1];
        end

        always_comb begin
            logic [67:0] r4, trial, diff;
            logic        ge;
            st_next = st_cur;
            // Bring down two radicand bits, try root*4+1.
            r4    = {st_cur.rem, st_cur.n[127:126]};
            trial = {2'b00, st_cur.root, 2'b01};
            diff  = r4 - trial;
            ge    = (r4 >= trial);
            st_next.rem  = ge ? diff[65:0] : r4[65:0];
            st_next.root = {st_cur.root[62:0], ge};
            st_next.n    = {st_cur.n[125:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next;
            end
        end
    end

    assign out_valid      = vld_reg[pn_pkg::SQRT_STEPS-1];
    assign out_data.tag   = st_reg[pn_pkg::SQRT_STEPS-1].tag;
    assign out_data.rzero = st_reg[pn_pkg::SQRT_STEPS-1].rzero;
    assign out_data.wneg  = st_reg[pn_pkg::SQRT_STEPS-1].wneg;
    assign out_data.wmag  = st_reg[pn_pkg::SQRT_STEPS-1].wmag;
    assign out_data.k     = st_reg[pn_pkg::SQRT_STEPS-1].root;

endmodule

`default_nettype wire

### design/pn_back.sv
// Back end: gain and speed-ratio scaling, rounding, saturation and the output register.
// Uses pn_pkg for CONTROL_DIMS and the root_t payload; four register stages.
`default_nettype none

module pn_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [15:0]         gain,
    input  logic                in_valid,
    input  pn_pkg::root_t       in_data,
    output logic                out_valid,
    output logic [31:0]         out_tag,
    output logic signed [31:0]  out_accel_x,
    output logic signed [31:0]  out_accel_y,
    output logic signed [31:0]  out_accel_z,
    output logic                out_range_zero,
    output logic                out_saturated
);

    logic [3:0] vld_reg;

    logic [31:0]       t1_reg, t2_reg, t3_reg;
    logic              rz1_reg, rz2_reg, rz3_reg;
    logic [2:0]        wn1_reg, wn2_reg, wn3_reg;
    logic [63:0]       k1_reg;
    logic [2:0][49:0]  wg1_reg, wg1_next;
    logic [2:0][63:0]  ll2_reg, lh2_reg, ll2_next, lh2_next;
    logic [2:0][49:0]  hl2_reg, hh2_reg, hl2_next, hh2_next;
    logic [2:0][115:0] m3_reg, m3_next;

    logic [2:0][31:0]  acc_reg, acc_next;
    logic [31:0]       tag_reg;
    logic              rz_reg, sat_reg, sat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wg1_next[i] = 50'(in_data.wmag[i]) * 50'(gain);
        end
    end

    // Four 32-bit-class partial products of wg * k.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ll2_next[i] = 64'(wg1_reg[i][31:0]) * 64'(k1_reg[31:0]);
            lh2_next[i] = 64'(wg1_reg[i][31:0]) * 64'(k1_reg[63:32]);
            hl2_next[i] = 50'(wg1_reg[i][49:32]) * 50'(k1_reg[31:0]);
            hh2_next[i] = 50'(wg1_reg[i][49:32]) * 50'(k1_reg[63:32]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m3_next[i] = 116'(ll2_reg[i])
                       + (116'(lh2_reg[i]) << 32)
                       + (116'(hl2_reg[i]) << 32)
                       + (116'(hh2_reg[i]) << 64)
                       + (116'(1) << 39);
        end
    end

    // Drop 40 fraction bits, clip to the signed 32-bit range, apply sign.
    always_comb begin
        logic [31:0] am, lim, amc;
        logic        clip;
        sat_next = 1'b0;
        acc_next = '0;
        for (int i = 0; i < 3; i++) begin
            am   = m3_reg[i][71:40];
            lim  = wn3_reg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            clip = (|m3_reg[i][115:72]) || (am > lim);
            amc  = clip ? lim : am;
            if (!rz3_reg && !(pn_pkg::CONTROL_DIMS == 2 && i == 2)) begin
                acc_next[i] = wn3_reg[i] ? (~amc + 32'd1) : amc;
                sat_next    = sat_next | clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= in_data.tag;
            rz1_reg <= in_data.rzero;
            wn1_reg <= in_data.wneg;
            k1_reg  <= in_data.k;
            wg1_reg <= wg1_next;

            t2_reg  <= t1_reg;
            rz2_reg <= rz1_reg;
            wn2_reg <= wn1_reg;
            ll2_reg <= ll2_next;
            lh2_reg <= lh2_next;
            hl2_reg <= hl2_next;
            hh2_reg <= hh2_next;

            t3_reg  <= t2_reg;
            rz3_reg <= rz2_reg;
            wn3_reg <= wn2_reg;
            m3_reg  <= m3_next;

            tag_reg <= t3_reg;
            rz_reg  <= rz3_reg;
            sat_reg <= sat_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid      = vld_reg[3];
    assign out_tag        = tag_reg;
    assign out_accel_x    = acc_reg[0];
    assign out_accel_y    = acc_reg[1];
    assign out_accel_z    = acc_reg[2];
    assign out_range_zero = rz_reg;
    assign out_saturated  = sat_reg;

endmodule

`default_nettype wire

### design/proportional_navigation_accel.sv
// Top level: handshake, navigation gain register and the four pipeline sections.
// Uses pn_pkg, pn_front, pn_div, pn_sqrt and pn_back.
`default_nettype none

// Proportional navigation command engine. Takes one relative position/velocity
// sample per cycle and returns a = N*|v|/|r| * (v - r(r.v)/(r.r)) with the time
// tag, one result per sample, in order. The pipeline is 6 front-end stages,
// 128 stages of the bit-per-stage divider for (v.v)*2^64/(r.r) (the projection
// divide runs in its first 32), one stage to form the perpendicular velocity,
// 64 square-root stages and 4 scaling and saturation stages. The whole pipeline
// advances together whenever the result register is empty or being taken, so
// throughput is one word per cycle while m_ready stays high. nav_gain sits at
// address 0 and should only be written while no sample is in flight.
module proportional_navigation_accel (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_time_tag,
    input  logic signed [31:0]          s_rel_pos_x,
    input  logic signed [31:0]          s_rel_pos_y,
    input  logic signed [31:0]          s_rel_pos_z,
    input  logic signed [31:0]          s_rel_vel_x,
    input  logic signed [31:0]          s_rel_vel_y,
    input  logic signed [31:0]          s_rel_vel_z,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [31:0]                 m_out_time_tag,
    output logic signed [31:0]          m_accel_x,
    output logic signed [31:0]          m_accel_y,
    output logic signed [31:0]          m_accel_z,
    output logic                        m_range_zero,
    output logic                        m_saturated,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pn_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic            en;
    logic [15:0]     gain_reg;
    logic            front_vld, mid_vld, root_vld;
    pn_pkg::front_t  front_data;
    pn_pkg::mid_t    mid_data;
    pn_pkg::root_t   root_data;

    // Advance everything unless a finished word is held at the output.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= pn_pkg::NAV_GAIN_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == pn_pkg::REG_NAV_GAIN)) begin
            gain_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == pn_pkg::REG_NAV_GAIN) ? {16'd0, gain_reg} : 32'd0;

    pn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_tag    (s_time_tag),
        .in_pos_x  (s_rel_pos_x),
        .in_pos_y  (s_rel_pos_y),
        .in_pos_z  (s_rel_pos_z),
        .in_vel_x  (s_rel_vel_x),
        .in_vel_y  (s_rel_vel_y),
        .in_vel_z  (s_rel_vel_z),
        .out_valid (front_vld),
        .out_data  (front_data)
    );

    pn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_vld),
        .in_data   (front_data),
        .out_valid (mid_vld),
        .out_data  (mid_data)
    );

    pn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mid_vld),
        .in_data   (mid_data),
        .out_valid (root_vld),
        .out_data  (root_data)
    );

    pn_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .gain           (gain_reg),
        .in_valid       (root_vld),
        .in_data        (root_data),
        .out_valid      (m_valid),
        .out_tag        (m_out_time_tag),
        .out_accel_x    (m_accel_x),
        .out_accel_y    (m_accel_y),
        .out_accel_z    (m_accel_z),
        .out_range_zero (m_range_zero),
        .out_saturated  (m_saturated)
    );

endmodule

`default_nettype wire

### dv/pn_checker.sv
// Result checker for the proportional navigation engine: watches both word channels
// and the gain register port, predicts each command and compares in order.
// Depends on pn_pkg for the dimension parameters and the gain register index.
module pn_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [31:0]                 s_time_tag,
    input  logic signed [31:0]          s_rel_pos_x,
    input  logic signed [31:0]          s_rel_pos_y,
    input  logic signed [31:0]          s_rel_pos_z,
    input  logic signed [31:0]          s_rel_vel_x,
    input  logic signed [31:0]          s_rel_vel_y,
    input  logic signed [31:0]          s_rel_vel_z,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [31:0]                 m_out_time_tag,
    input  logic signed [31:0]          m_accel_x,
    input  logic signed [31:0]          m_accel_y,
    input  logic signed [31:0]          m_accel_z,
    input  logic                        m_range_zero,
    input  logic                        m_saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [pn_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output int                          fail_count,
    output int                          pending,
    output int                          commands_seen,
    output int                          zero_range_seen,
    output int                          clipped_seen
);

    typedef struct {
        logic [31:0] tag;
        logic [31:0] acc [3];
        logic        rzero;
        logic        sat;
    } command_t;

    command_t    expected_cmds [$];
    logic [15:0] gain;

    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] root128(logic [127:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
        end
        return res;
    endfunction

    function automatic command_t predict_command(logic [31:0] tag,
                                                 logic signed [31:0] pos [3],
                                                 logic signed [31:0] vel [3],
                                                 logic [15:0] n_gain);
        command_t           c;
        logic signed [63:0] r [3];
        logic signed [63:0] v [3];
        logic [63:0]        rm, vm, p, q, dpos, dneg, dmag, k, lim;
        logic               dneg_sign, tneg, wneg;
        logic [127:0]       num, t, m, am;
        logic signed [95:0] ws;
        logic [95:0]        wm;
        int                 dims, cdims;
        dims  = (pn_pkg::STATE_DIMS == 2) ? 2 : 3;
        cdims = (pn_pkg::CONTROL_DIMS == 2) ? 2 : 3;
        c.tag = tag;
        c.rzero = 1'b0;
        c.sat = 1'b0;
        for (int i = 0; i < 3; i++) c.acc[i] = '0;
        p = '0; q = '0; dpos = '0; dneg = '0;
        for (int i = 0; i < 3; i++) begin
            r[i] = (i < dims) ? 64'(pos[i]) : 64'sd0;
            v[i] = (i < dims) ? 64'(vel[i]) : 64'sd0;
            rm = magnitude(r[i]);
            vm = magnitude(v[i]);
            p += rm * rm;
            q += vm * vm;
            if ((r[i] < 0) != (v[i] < 0)) dneg += rm * vm;
            else dpos += rm * vm;
        end
        if (p == 0) begin
            c.rzero = 1'b1;
            return c;
        end
        dneg_sign = dneg > dpos;
        dmag = dneg_sign ? dneg - dpos : dpos - dneg;
        k = root128({q, 64'd0} / {64'd0, p});
        for (int i = 0; i < cdims; i++) begin
            num = {64'd0, magnitude(r[i])} * {64'd0, dmag} + {65'd0, p[63:1]};
            t = num / {64'd0, p};
            tneg = (r[i] < 0) != dneg_sign;
            ws = tneg ? 96'(v[i]) + $signed({32'd0, t[63:0]})
                      : 96'(v[i]) - $signed({32'd0, t[63:0]});
            wneg = ws < 0;
            wm = wneg ? 96'(-ws) : 96'(ws);
            m = {32'd0, wm} * {112'd0, n_gain} * {64'd0, k} + (128'd1 << 39);
            am = m >> 40;
            lim = wneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (am > {64'd0, lim}) begin
                am = {64'd0, lim};
                c.sat = 1'b1;
            end
            c.acc[i] = wneg ? -am[31:0] : am[31:0];
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        commands_seen = 0;
        zero_range_seen = 0;
        clipped_seen = 0;
    end

    always @(posedge aclk) begin
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        command_t           want;
        if (!aresetn) begin
            gain <= pn_pkg::NAV_GAIN_RESET;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == pn_pkg::PADDR_W'(4 * pn_pkg::REG_NAV_GAIN))
                gain <= pwdata[15:0];
            if (s_valid && s_ready) begin
                pos = '{s_rel_pos_x, s_rel_pos_y, s_rel_pos_z};
                vel = '{s_rel_vel_x, s_rel_vel_y, s_rel_vel_z};
                expected_cmds.push_back(predict_command(s_time_tag, pos, vel, gain));
            end
            if (m_valid && m_ready) begin
                commands_seen++;
                if (m_range_zero) zero_range_seen++;
                if (m_saturated) clipped_seen++;
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected word, tag", m_out_time_tag, 32'd0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_out_time_tag !== want.tag)
                        report_mismatch("out_time_tag", m_out_time_tag, want.tag);
                    if (m_accel_x !== want.acc[0])
                        report_mismatch("accel_x", m_accel_x, want.acc[0]);
                    if (m_accel_y !== want.acc[1])
                        report_mismatch("accel_y", m_accel_y, want.acc[1]);
                    if (m_accel_z !== want.acc[2])
                        report_mismatch("accel_z", m_accel_z, want.acc[2]);
                    if (m_range_zero !== want.rzero)
                        report_mismatch("range_zero", 32'(m_range_zero), 32'(want.rzero));
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", 32'(m_saturated), 32'(want.sat));
                end
            end
        end
        pending = expected_cmds.size();
    end

endmodule

### dv/testbench.sv
// Top of the proportional navigation engine bench: clock, reset, sample and gain
// stimulus, result-side stalls and the verdict. Uses pn_pkg, pn_checker and the block.
module testbench;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [31:0]                 s_time_tag;
    logic signed [31:0]          s_rel_pos_x, s_rel_pos_y, s_rel_pos_z;
    logic signed [31:0]          s_rel_vel_x, s_rel_vel_y, s_rel_vel_z;
    logic                        m_valid;
    logic                        m_ready;
    logic [31:0]                 m_out_time_tag;
    logic signed [31:0]          m_accel_x, m_accel_y, m_accel_z;
    logic                        m_range_zero, m_saturated;
    logic                        psel, penable, pwrite, pready;
    logic [pn_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata, prdata;

    int   fail_count, pending, commands_seen, zero_range_seen, clipped_seen;
    logic calm;
    logic hold_req;
    logic [31:0] next_tag;

    proportional_navigation_accel dut (.*);
    pn_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_time_tag = '0;
        {s_rel_pos_x, s_rel_pos_y, s_rel_pos_z} = '0;
        {s_rel_vel_x, s_rel_vel_y, s_rel_vel_z} = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        next_tag = '0;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        logic held;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                held = 1'b1;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic write_gain(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pn_pkg::PADDR_W'(4 * pn_pkg::REG_NAV_GAIN);
        pwdata <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        s_valid <= 1'b1;
        s_time_tag <= next_tag;
        s_rel_pos_x <= px;
        s_rel_pos_y <= py;
        s_rel_pos_z <= pz;
        s_rel_vel_x <= vx;
        s_rel_vel_y <= vy;
        s_rel_vel_z <= vz;
        do @(posedge aclk); while (!s_ready);
        next_tag = next_tag + $urandom_range(1, 1000);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_value(int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return 32'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
            default: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
        endcase
    endfunction

    task automatic send_random;
        int pstyle, vstyle, shape;
        logic [31:0] p [3];
        logic [31:0] v [3];
        pstyle = $urandom_range(0, 3);
        vstyle = $urandom_range(0, 3);
        shape = $urandom_range(0, 19);
        for (int i = 0; i < 3; i++) begin
            p[i] = pick_value(pstyle);
            v[i] = pick_value(vstyle);
        end
        if (shape == 0) p = '{0, 0, 0};
        if (shape == 1) v = '{0, 0, 0};
        if (shape == 2) v = p;
        send_sample(p[0], p[1], p[2], v[0], v[1], v[2]);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] gains [6];
        gains = '{16'd768, 16'd65535, 16'd0, 16'd1, 16'd256, 16'($urandom())};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero range, zero velocity, field extremes, pure closing and crossing.
        send_sample(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(32'h0001_0000, 0, 0, 0, 0, 0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_sample(1, 0, 0, 0, 32'h7FFF_FFFF, 0);
        send_sample(1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0064_0000, 0, 0, 32'hFFF6_0000, 0, 0);
        send_sample(32'h0064_0000, 0, 0, 0, 32'h000A_0000, 0);
        send_sample(0, 0, 32'h0064_0000, 32'h0005_0000, 0, 32'hFFFF_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 5, 7);
        send_sample(32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000,
                    32'hFFFF_8000, 32'h0001_8000, 32'h0000_4000);
        next_tag = 32'hFFFF_FFF0;
        send_sample(2, 3, 0, 32'h0000_FFFF, 0, 32'h0001_0000);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_gain(gains[ph]);
            if (ph == 1) hold_req = 1'b1;
            if (ph == 5) calm = 1'b1;
            repeat (280) send_random();
        end
        drain();
        repeat (250) @(posedge aclk);

        $display("%0d commands checked over 6 gain settings, %0d zero-range, %0d clipped",
                 commands_seen, zero_range_seen, clipped_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
